>>> sv/apt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants for the affine point transform core.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int COORD_W       = 32;
  localparam int PROD_W        = 2 * COORD_W;
  localparam int NUM_AXES      = 3;
  localparam int MAT_COLS      = 4;
  localparam int MAT_DEPTH     = NUM_AXES * MAT_COLS;
  localparam int IDX_W         = 4;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [IDX_W-1:0]          entry_idx_t;

  // request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = -32'sh7FFF_FFFF - 32'sd1;

endpackage : apt_pkg
`default_nettype wire

>>> sv/apt_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_channels
// Valid/ready channels: request (matrix write or point) and transformed point.
// ----------------------------------------------------------------------------
interface apt_req_if;
  logic                valid;
  logic                ready;
  logic                kind;
  apt_pkg::entry_idx_t entry_index;
  apt_pkg::coord_t     entry_value;
  apt_pkg::coord_t     point_x;
  apt_pkg::coord_t     point_y;
  apt_pkg::coord_t     point_z;

  modport source (output valid, kind, entry_index, entry_value, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, kind, entry_index, entry_value, point_x, point_y, point_z,
                  output ready);
endinterface : apt_req_if

interface apt_rsp_if;
  logic            valid;
  logic            ready;
  apt_pkg::coord_t out_x;
  apt_pkg::coord_t out_y;
  apt_pkg::coord_t out_z;
  logic            saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface : apt_rsp_if
`default_nettype wire

>>> sv/apt_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_mul
// Stage 1: nine signed 32x32 products plus registered translation column.
// ----------------------------------------------------------------------------
module apt_mul (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire apt_pkg::coord_t coef [apt_pkg::NUM_AXES][apt_pkg::NUM_AXES],
  input  wire apt_pkg::coord_t trans_in [apt_pkg::NUM_AXES],
  input  wire apt_pkg::coord_t point [apt_pkg::NUM_AXES],
  output logic                 out_valid,
  input  wire logic            out_ready,
  output apt_pkg::prod_t       prod [apt_pkg::NUM_AXES][apt_pkg::NUM_AXES],
  output apt_pkg::coord_t      trans [apt_pkg::NUM_AXES]
);
  import apt_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        trans[r] <= trans_in[r];
        for (int c = 0; c < NUM_AXES; c++) begin
          prod[r][c] <= PROD_W'(coef[r][c]) * PROD_W'(point[c]);
        end
      end
    end
  end

endmodule : apt_mul
`default_nettype wire

>>> sv/apt_sum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_sum
// Stages 2 and 3: floor shift of the products and a two-level adder tree.
// ----------------------------------------------------------------------------
module apt_sum #(
  parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF,
  parameter int SUM_W     = apt_pkg::PROD_W - FRAC_BITS + 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire apt_pkg::prod_t  prod [apt_pkg::NUM_AXES][apt_pkg::NUM_AXES],
  input  wire apt_pkg::coord_t trans [apt_pkg::NUM_AXES],
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic signed [SUM_W-1:0] sum [apt_pkg::NUM_AXES]
);
  import apt_pkg::*;

  localparam int PART_W = SUM_W - 1;
  localparam int SH_W   = SUM_W - 2;

  logic                     mid_valid;
  logic                     mid_ready;
  logic signed [PART_W-1:0] part_a [NUM_AXES];
  logic signed [PART_W-1:0] part_b [NUM_AXES];
  logic signed [SH_W-1:0]   sh     [NUM_AXES][NUM_AXES];

  // arithmetic shift rounds toward minus infinity
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        sh[r][c] = SH_W'(prod[r][c] >>> FRAC_BITS);
      end
    end
  end

  assign in_ready  = !mid_valid || mid_ready;
  assign mid_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mid_valid <= in_valid;
      end
      if (mid_ready) begin
        out_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        part_a[r] <= PART_W'(sh[r][0]) + PART_W'(sh[r][1]);
        part_b[r] <= PART_W'(sh[r][2]) + PART_W'(trans[r]);
      end
    end
    if (mid_valid && mid_ready) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        sum[r] <= SUM_W'(part_a[r]) + SUM_W'(part_b[r]);
      end
    end
  end

endmodule : apt_sum
`default_nettype wire

>>> sv/apt_sat.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apt_sat
// Stage 4: clip each sum to 32 bits, flag clipping, drive the output register.
// ----------------------------------------------------------------------------
module apt_sat #(
  parameter int SUM_W = apt_pkg::PROD_W - apt_pkg::FRAC_BITS_DEF + 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [SUM_W-1:0] sum [apt_pkg::NUM_AXES],
  apt_rsp_if.source               rsp
);
  import apt_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(COORD_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(COORD_MIN);

  coord_t                clip [NUM_AXES];
  logic [NUM_AXES-1:0]   hit;

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      if (sum[r] > SUM_MAX) begin
        clip[r] = COORD_MAX;
        hit[r]  = 1'b1;
      end else if (sum[r] < SUM_MIN) begin
        clip[r] = COORD_MIN;
        hit[r]  = 1'b1;
      end else begin
        clip[r] = COORD_W'(sum[r]);
        hit[r]  = 1'b0;
      end
    end
  end

  assign in_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (in_ready) begin
      rsp.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rsp.out_x     <= clip[0];
      rsp.out_y     <= clip[1];
      rsp.out_z     <= clip[2];
      rsp.saturated <= |hit;
    end
  end

endmodule : apt_sat
`default_nettype wire

>>> sv/affine_point_transform_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_point_transform_core
// 3x4 affine transform of Q15.16 points, matrix loaded by write requests.
// ----------------------------------------------------------------------------
// Pipeline: a point request is multiplied into the stage-1 register at its
//   accepting edge, then passes the partial-sum, final-sum and saturate stages.
// Throughput: one request per cycle while no stage is held; each of the four stages has its own
//   valid bit and stalls only when it is full and the stage after it is held.
// Reset: matrix returns to identity, all stage valid bits clear.
// ----------------------------------------------------------------------------
module affine_point_transform_core #(
  parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  apt_req_if.sink   req,
  apt_rsp_if.source rsp
);
  import apt_pkg::*;

  // sum width: shifted 64-bit product plus headroom for four terms
  localparam int SUM_W = PROD_W - FRAC_BITS + 2;
  localparam coord_t ONE = COORD_W'(64'sd1 <<< FRAC_BITS);

  // Matrix entries, row*4 + column. A write changes the matrix at the edge
  // it is accepted, so a point accepted next already sees the new value.
  coord_t mat [MAT_DEPTH];

  coord_t coef     [NUM_AXES][NUM_AXES];
  coord_t trans_in [NUM_AXES];
  coord_t point    [NUM_AXES];

  logic   req_point;
  logic   mul_ready;
  logic   mul_valid;
  logic   sum_ready;
  logic   sum_valid;
  logic   sat_ready;
  prod_t  prod  [NUM_AXES][NUM_AXES];
  coord_t trans [NUM_AXES];
  logic signed [SUM_W-1:0] sum [NUM_AXES];

  // Write requests are consumed at the door; only points enter the pipeline.
  // The door stays open for writes even while the multiplier stage is held.
  assign req_point = req.valid && (req.kind == KIND_POINT);
  assign req.ready = (req.kind == KIND_WRITE) || mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      // identity: ones on the diagonal, zero translation
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < MAT_COLS; c++) begin
          mat[r * MAT_COLS + c] <= (c == r) ? ONE : '0;
        end
      end
    end else if (req.valid && req.ready && (req.kind == KIND_WRITE)) begin
      // entries 12..15 do not exist: such writes are dropped
      if (req.entry_index < IDX_W'(MAT_DEPTH)) begin
        mat[req.entry_index] <= req.entry_value;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      trans_in[r] = mat[r * MAT_COLS + NUM_AXES];
      for (int c = 0; c < NUM_AXES; c++) begin
        coef[r][c] = mat[r * MAT_COLS + c];
      end
    end
    point[0] = req.point_x;
    point[1] = req.point_y;
    point[2] = req.point_z;
  end

  apt_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_point),
    .in_ready  (mul_ready),
    .coef      (coef),
    .trans_in  (trans_in),
    .point     (point),
    .out_valid (mul_valid),
    .out_ready (sum_ready),
    .prod      (prod),
    .trans     (trans)
  );

  apt_sum #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SUM_W)
  ) u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (sum_ready),
    .prod      (prod),
    .trans     (trans),
    .out_valid (sum_valid),
    .out_ready (sat_ready),
    .sum       (sum)
  );

  apt_sat #(
    .SUM_W (SUM_W)
  ) u_sat (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sum_valid),
    .in_ready (sat_ready),
    .sum      (sum),
    .rsp      (rsp)
  );

endmodule : affine_point_transform_core
`default_nettype wire

>>> bench/tb_affine_point_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_affine_point_transform_core
// Self-checking bench for the affine point transform core. Matrix-write and
// point requests are streamed in under random gaps and response back-pressure;
// a shadow copy of the matrix predicts every transformed point, and each
// response is checked in order against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_affine_point_transform_core;
  import apt_pkg::*;

  localparam int     FRAC         = FRAC_BITS_DEF;
  localparam coord_t ONE          = 32'sd1 <<< FRAC;   // 1.0 in fixed point
  localparam int     RANDOM_ITEMS = 700;
  localparam int     MAX_REPORTS  = 10;
  localparam int     TAIL_CYCLES  = 12;                // pipeline is 4 deep
  // ~725 requests, each worst case a long idle gap, a long response stall and the pipeline
  localparam int     CYCLE_LIMIT  = 300000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } xpoint_t;

  logic clk;
  logic rst;

  apt_req_if req_ch ();
  apt_rsp_if rsp_ch ();

  affine_point_transform_core #(
    .FRAC_BITS (FRAC)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow matrix, row-major 3x4, updated when a write request is accepted
  coord_t  shadow_mat [MAT_DEPTH];
  // Predicted points, oldest first
  xpoint_t pending_pts [$];

  int mismatches  = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  bit calm        = 1'b1;   // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // Each product is exact in 64 bits and floored by the arithmetic shift;
  // the three shifted products plus translation are summed exactly, then
  // clipped to 32 bits. The flag is the OR over all three axes.
  // --------------------------------------------------------------------------
  function automatic xpoint_t transform_point(coord_t px, coord_t py, coord_t pz);
    coord_t  p   [NUM_AXES];
    coord_t  res [NUM_AXES];
    longint  acc;
    xpoint_t r;
    p[0]  = px;
    p[1]  = py;
    p[2]  = pz;
    r.sat = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      acc = longint'(shadow_mat[a * MAT_COLS + NUM_AXES]);
      for (int c = 0; c < NUM_AXES; c++)
        acc += (longint'(shadow_mat[a * MAT_COLS + c]) * longint'(p[c])) >>> FRAC;
      if (acc > longint'(COORD_MAX)) begin
        res[a] = COORD_MAX;
        r.sat  = 1'b1;
      end else if (acc < longint'(COORD_MIN)) begin
        res[a] = COORD_MIN;
        r.sat  = 1'b1;
      end else begin
        res[a] = coord_t'(acc);
      end
    end
    r.x = res[0];
    r.y = res[1];
    r.z = res[2];
    return r;
  endfunction

  // Idle length for either side: mostly none, sometimes short, rarely long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random fixed-point value: usually within +/- 2^mag_log2, otherwise any
  // 32-bit pattern or one of the corner values
  function automatic coord_t rand_value(int unsigned mag_log2);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return coord_t'($urandom_range(0, 32'd2 << (FRAC + mag_log2)))
             - (32'sd1 <<< (FRAC + mag_log2));
    if (r < 85) return coord_t'($urandom);
    case ($urandom_range(0, 5))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return ONE;
      4:       return -ONE;
      default: return -32'sd1;     // smallest negative fraction
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // valid is left high after acceptance; the next call either drives the next
  // request in the same step or lowers valid for its gap.
  // --------------------------------------------------------------------------
  task automatic send_request(logic kind, entry_idx_t idx, coord_t val,
                              coord_t px, coord_t py, coord_t pz);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= kind;
    req_ch.entry_index <= idx;
    req_ch.entry_value <= val;
    req_ch.point_x     <= px;
    req_ch.point_y     <= py;
    req_ch.point_z     <= pz;
    do @(posedge clk); while (!req_ch.ready);
    // accepted at this edge
    if (kind == KIND_WRITE) begin
      if (idx < MAT_DEPTH) shadow_mat[idx] = val;
    end else begin
      pending_pts.push_back(transform_point(px, py, pz));
    end
  endtask

  // Point fields of a write carry junk: they must be ignored
  task automatic write_entry(entry_idx_t idx, coord_t val);
    send_request(KIND_WRITE, idx, val,
                 coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  // Likewise the entry fields of a point request
  task automatic send_point(coord_t px, coord_t py, coord_t pz);
    send_request(KIND_POINT, entry_idx_t'($urandom), coord_t'($urandom), px, py, pz);
  endtask

  // Hold off the request side until every outstanding point has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_pts.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Response side: random back-pressure, then in-order check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_throttle
    int unsigned gap;
    if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      gap = pick_gap();
      rsp_ch.ready <= (gap == 0);
      stall_left   <= (gap == 0) ? 0 : int'(gap) - 1;
    end
  end

  always @(posedge clk) begin : rsp_check
    xpoint_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_pts.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("[%0t] unexpected point: x=%h y=%h z=%h sat=%b", $realtime,
                   rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.saturated);
        mismatches++;
      end else begin
        want = pending_pts.pop_front();
        if (rsp_ch.out_x !== want.x || rsp_ch.out_y !== want.y ||
            rsp_ch.out_z !== want.z || rsp_ch.saturated !== want.sat) begin
          if (mismatches < MAX_REPORTS)
            $display("[%0t] point mismatch: exp x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                     $realtime, want.x, want.y, want.z, want.sat,
                     rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.saturated);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("affine_point_transform_core verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset the matrix is identity: coordinates pass straight through
  task automatic test_identity_points();
    calm = 1'b1;
    send_point(COORD_MAX, COORD_MIN, '0);
    send_point(-32'sd1, 32'sd1, ONE + (ONE >>> 1));
    send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  // Extreme coefficients, both clip directions, and ignored high indices
  task automatic test_entry_extremes();
    calm = 1'b0;
    write_entry(4'd3, COORD_MAX);
    write_entry(4'd0, COORD_MIN);
    send_point(ONE, ONE, ONE);          // MIN + MAX lands on -1, no clip
    send_point(-ONE, '0, '0);           // 2^31 + MAX: clips high
    send_point(ONE <<< 1, '0, '0);      // 2*MIN + MAX: clips low
    write_entry(4'd12, coord_t'($urandom));
    write_entry(4'd15, COORD_MIN);
    send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    write_entry(4'd0, ONE);
    write_entry(4'd3, '0);
  endtask

  // Shifted products floor towards minus infinity
  task automatic test_floor_rounding();
    write_entry(4'd5, 32'sd1);
    send_point('0, -32'sd1, '0);        // tiny negative product floors to -1
    send_point('0, 32'sd1, '0);         // tiny positive product drops to 0
    send_point('0, -ONE, '0);
    write_entry(4'd5, ONE);
  endtask

  // Translation at the rails: exact boundary passes, one step past clips
  task automatic test_sum_saturation();
    write_entry(4'd11, COORD_MAX);
    send_point('0, '0, '0);
    send_point('0, '0, ONE);
    write_entry(4'd11, COORD_MIN);
    send_point('0, '0, -ONE);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);
    write_entry(4'd11, '0);
    wait_drained();
  endtask

  // Mixed stream: mostly points, single writes, occasional full reloads
  task automatic test_random_stream();
    int          n;
    int unsigned r;
    entry_idx_t  idx;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(0, 49) == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // whole matrix back to back
        for (int e = 0; e < MAT_DEPTH; e++) write_entry(entry_idx_t'(e), rand_value(2));
        n += MAT_DEPTH;
      end else if (r < 24) begin
        if ($urandom_range(0, 9) == 0) begin
          idx = entry_idx_t'($urandom_range(MAT_DEPTH, (1 << IDX_W) - 1));
        end else begin
          idx = entry_idx_t'($urandom_range(0, MAT_DEPTH - 1));
          n++;
        end
        write_entry(idx, rand_value(2));
      end else begin
        send_point(rand_value(10), rand_value(10), rand_value(10));
        n++;
      end
    end
  endtask

  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.kind        <= KIND_WRITE;
    req_ch.entry_index <= '0;
    req_ch.entry_value <= '0;
    req_ch.point_x     <= '0;
    req_ch.point_y     <= '0;
    req_ch.point_z     <= '0;
    // identity: ones on the diagonal (indices 0, 5, 10)
    for (int i = 0; i < MAT_DEPTH; i++)
      shadow_mat[i] = (i % (MAT_COLS + 1) == 0) ? ONE : '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_identity_points();
    test_entry_extremes();
    test_floor_rounding();
    test_sum_saturation();
    test_random_stream();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("affine_point_transform_core verification clean");
    end else begin
      $display("affine_point_transform_core verification failed");
    end
    $finish;
  end

endmodule : tb_affine_point_transform_core
